// ===== hdl/slr_pkg.sv =====
// Shared types and constants for the scaled line rasterizer.
package slr_pkg;

    localparam int COORD_BITS = 6;
    localparam int REAL_BITS = 8;
    localparam int VIRT_BITS = 7;
    localparam int GLYPH_BITS = 8;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = 1;
    // Dividend and divisor widths of the shared divider.
    localparam int DIV_NUM_BITS = 24;
    localparam int DIV_DEN_BITS = 16;
    localparam int DIV_CNT_BITS = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_REAL_ROWS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REAL_COLS = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIRT_ROWS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VIRT_COLS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH = 3'd4;

    typedef struct packed {
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_line_in;

    typedef struct packed {
        logic [7:0] screen_row;
        logic [7:0] screen_col;
        logic [GLYPH_BITS-1:0] glyph;
        logic last_point;
    } t_point_out;

    // Classified line command handed from the front end to the stepper.
    typedef struct packed {
        logic vertical;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] hi;
        logic [COORD_BITS-1:0] fixed_x;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
        logic [COORD_BITS-1:0] den;
        logic num_neg;
        logic [COORD_BITS-1:0] num_mag;
    } t_line_cmd;

endpackage

// ===== hdl/slr_front.sv =====
// Front end: latches line commands, classifies them and queues them.
module slr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  slr_pkg::t_line_in   i_line,
    output logic                o_cmd_valid,
    output slr_pkg::t_line_cmd  o_cmd,
    input  logic                i_cmd_take
);

    slr_pkg::t_line_cmd n_cmd;
    slr_pkg::t_line_cmd r_q [slr_pkg::QUEUE_DEPTH];
    logic [slr_pkg::QUEUE_PTR_BITS-1:0] r_wr;
    logic [slr_pkg::QUEUE_PTR_BITS-1:0] r_rd;
    logic [slr_pkg::QUEUE_PTR_BITS:0]   r_cnt;
    logic wr_en;
    logic rd_en;

    // Classify: horizontal span over x, vertical span over y, slope sign.
    always_comb begin
        logic x_lt;
        logic y_lt;
        x_lt = i_line.start_x < i_line.end_x;
        y_lt = i_line.start_y < i_line.end_y;
        n_cmd.vertical = (i_line.start_x == i_line.end_x);
        n_cmd.fixed_x = i_line.start_x;
        n_cmd.x2 = i_line.end_x;
        n_cmd.y2 = i_line.end_y;
        if (n_cmd.vertical) begin
            n_cmd.lo = y_lt ? i_line.start_y : i_line.end_y;
            n_cmd.hi = y_lt ? i_line.end_y : i_line.start_y;
        end else begin
            n_cmd.lo = x_lt ? i_line.start_x : i_line.end_x;
            n_cmd.hi = x_lt ? i_line.end_x : i_line.start_x;
        end
        n_cmd.den = x_lt ? (i_line.end_x - i_line.start_x)
                         : (i_line.start_x - i_line.end_x);
        n_cmd.num_mag = y_lt ? (i_line.end_y - i_line.start_y)
                             : (i_line.start_y - i_line.end_y);
        // Sign of the slope (y2-y1)/(x2-x1), i.e. of its numerator once den is made positive.
        n_cmd.num_neg = (i_line.start_y != i_line.end_y)
                      && ((y_lt && !x_lt) || (!y_lt && x_lt));
    end

    assign o_full = (r_cnt == (slr_pkg::QUEUE_PTR_BITS+1)'(slr_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rd];
    assign wr_en = i_push && !o_full;
    assign rd_en = i_cmd_take && o_cmd_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    // Queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (slr_pkg::QUEUE_PTR_BITS+1)'(wr_en)
                           - (slr_pkg::QUEUE_PTR_BITS+1)'(rd_en);
        end
    end

endmodule

// ===== hdl/slr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module slr_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [slr_pkg::DIV_NUM_BITS-1:0]    i_num,
    input  logic [slr_pkg::DIV_DEN_BITS-1:0]    i_den,
    output logic                                o_done,
    output logic [slr_pkg::DIV_NUM_BITS-1:0]    o_quot
);

    logic [slr_pkg::DIV_NUM_BITS-1:0] r_quot;
    logic [slr_pkg::DIV_DEN_BITS:0]   r_rem;
    logic [slr_pkg::DIV_DEN_BITS-1:0] r_den;
    logic [slr_pkg::DIV_CNT_BITS-1:0] r_cnt;
    logic r_busy;
    logic r_done;
    logic [slr_pkg::DIV_DEN_BITS:0] trial;
    logic ge;

    // Shift in next dividend bit and test against the divisor.
    assign trial = {r_rem[slr_pkg::DIV_DEN_BITS-1:0],
                    r_quot[slr_pkg::DIV_NUM_BITS-1]};
    assign ge = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[slr_pkg::DIV_NUM_BITS-2:0], ge};
            r_rem <= ge ? (trial - {1'b0, r_den}) : trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= slr_pkg::DIV_CNT_BITS'(slr_pkg::DIV_NUM_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== hdl/slr_back.sv =====
// Back end: steps each line, interpolates each non-vertical point and scales every point.
module slr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  slr_pkg::t_line_cmd                i_cmd,
    output logic                              o_cmd_take,
    input  logic [slr_pkg::REAL_BITS-1:0]     i_real_rows,
    input  logic [slr_pkg::REAL_BITS-1:0]     i_real_cols,
    input  logic [slr_pkg::VIRT_BITS-1:0]     i_virt_rows,
    input  logic [slr_pkg::VIRT_BITS-1:0]     i_virt_cols,
    input  logic [slr_pkg::GLYPH_BITS-1:0]    i_glyph,
    output logic                              o_empty,
    output slr_pkg::t_point_out               o_point,
    input  logic                              i_pop
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_POINT = 7'b0000010,
        ST_YDIV  = 7'b0000100,
        ST_RDIV  = 7'b0001000,
        ST_CDIV  = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } t_state;

    localparam int NB = slr_pkg::DIV_NUM_BITS;
    localparam int DB = slr_pkg::DIV_DEN_BITS;
    localparam int CB = slr_pkg::COORD_BITS;

    t_state r_state;
    slr_pkg::t_line_cmd r_cmd;
    logic [CB-1:0] r_i;
    logic [CB-1:0] r_vx;
    logic [CB-1:0] r_vy;
    logic [7:0] r_row;
    logic [7:0] r_col;
    logic r_last;
    logic r_out_valid;
    slr_pkg::t_point_out r_out;
    logic div_start;
    logic [NB-1:0] div_num;
    logic [DB-1:0] div_den;
    logic div_done;
    logic [NB-1:0] div_quot;
    logic [CB:0] dx;
    logic [2*CB+1:0] prod;
    logic [NB-1:0] t_val;
    logic [NB-1:0] sc_num;
    logic [DB-1:0] sc_den;
    logic [7:0] sc_real;
    logic [slr_pkg::VIRT_BITS-1:0] sc_virt;
    logic [CB-1:0] sc_coord;
    logic [7:0] sat_q;
    logic r_sc_go;
    logic sc_start;

    slr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Interpolation numerator 2*y2*den + 2*num*(i-x2) + den, never negative.
    always_comb begin
        logic [NB-1:0] base;
        logic [NB-1:0] term;
        dx = (r_i >= r_cmd.x2) ? {1'b0, r_i - r_cmd.x2} : {1'b0, r_cmd.x2 - r_i};
        prod = (2*CB+2)'(r_cmd.num_mag) * (2*CB+2)'(dx);
        base = NB'(2) * NB'(r_cmd.y2) * NB'(r_cmd.den) + NB'(r_cmd.den);
        term = NB'(prod) << 1;
        if ((r_i >= r_cmd.x2) != r_cmd.num_neg) begin
            t_val = base + term;
        end else begin
            t_val = base - term;
        end
    end

    // Scaling numerator for the axis in progress.
    always_comb begin
        sc_real = (r_state == ST_RDIV) ? i_real_rows : i_real_cols;
        sc_virt = (r_state == ST_RDIV) ? i_virt_rows : i_virt_cols;
        sc_coord = (r_state == ST_RDIV) ? r_vx : r_vy;
        sc_num = NB'(2) * NB'(sc_real) * NB'(sc_coord) + NB'(sc_virt);
        sc_den = DB'({sc_virt, 1'b0});
        sat_q = (div_quot > NB'(255)) ? 8'hFF : div_quot[7:0];
    end

    // Divider start: interpolation from the point state, scaling on axis entry.
    always_comb begin
        div_start = sc_start;
        div_num = sc_num;
        div_den = sc_den;
        if (r_state == ST_POINT && !r_cmd.vertical) begin
            div_start = 1'b1;
            div_num = t_val;
            div_den = DB'({r_cmd.den, 1'b0});
        end
    end

    assign o_cmd_take = (r_state == ST_IDLE) && i_cmd_valid;

    // Stepping sequencer: one point at a time through the shared divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_pop && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_i <= i_cmd.lo;
                        r_state <= ST_POINT;
                    end
                end
                ST_POINT: begin
                    r_last <= (r_i == r_cmd.hi);
                    if (r_cmd.vertical) begin
                        r_vx <= r_cmd.fixed_x;
                        r_vy <= r_i;
                        r_state <= ST_RDIV;
                    end else begin
                        r_vx <= r_i;
                        r_state <= ST_YDIV;
                    end
                end
                ST_YDIV: begin
                    if (div_done) begin
                        r_vy <= div_quot[CB-1:0];
                        r_state <= ST_RDIV;
                    end
                end
                ST_RDIV, ST_CDIV: begin
                    if (div_done) begin
                        if (r_state == ST_RDIV) begin
                            r_row <= (i_virt_rows == '0) ? 8'hFF : sat_q;
                            r_state <= ST_CDIV;
                        end else begin
                            r_col <= (i_virt_cols == '0) ? 8'hFF : sat_q;
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_valid <= 1'b1;
                        r_out.screen_row <= r_row;
                        r_out.screen_col <= r_col;
                        r_out.glyph <= i_glyph;
                        r_out.last_point <= r_last;
                        r_i <= r_i + 1'b1;
                        r_state <= r_last ? ST_IDLE : ST_POINT;
                    end
                end
                ST_WAIT: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Scaling divisions start on entry to each axis state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_go <= 1'b0;
        end else begin
            r_sc_go <= ((r_state == ST_POINT) && r_cmd.vertical)
                    || ((r_state == ST_YDIV) && div_done)
                    || ((r_state == ST_RDIV) && div_done);
        end
    end

    assign sc_start = r_sc_go && (r_state == ST_RDIV || r_state == ST_CDIV);

    assign o_empty = !r_out_valid;
    assign o_point = r_out;

endmodule

// ===== hdl/scaled_line_rasterizer_top.sv =====
// Top level of the scaled line rasterizer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------
//  line in  | i_push / o_full    | i_line (start_x, start_y, end_x, end_y)
//  point out| o_empty / i_pop    | o_point (screen_row, screen_col, glyph, last)
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A sloped point passes through three 24-step divisions in the shared divider
// (y interpolation, row scale, column scale) with their hand-over cycles,
// plus the point state and the emit state. A vertical line skips the
// interpolation, and each line takes its command in the idle state. A
// two-entry command queue lets new lines be taken while one is stepped.
// Reset is synchronous and active low; control and configuration registers return to their defaults.
// A stalled output holds its point and pauses the stepper.
module scaled_line_rasterizer_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  slr_pkg::t_line_in                      i_line,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output slr_pkg::t_point_out                    o_point,
    input  logic                                   i_cfg_we,
    input  logic [slr_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [slr_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    logic [slr_pkg::REAL_BITS-1:0]  r_real_rows;
    logic [slr_pkg::REAL_BITS-1:0]  r_real_cols;
    logic [slr_pkg::VIRT_BITS-1:0]  r_virt_rows;
    logic [slr_pkg::VIRT_BITS-1:0]  r_virt_cols;
    logic [slr_pkg::GLYPH_BITS-1:0] r_glyph;
    logic cmd_valid;
    logic cmd_take;
    slr_pkg::t_line_cmd cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_rows <= 8'd24;
            r_real_cols <= 8'd80;
            r_virt_rows <= 7'd64;
            r_virt_cols <= 7'd64;
            r_glyph <= 8'd42;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slr_pkg::CFG_REAL_ROWS: r_real_rows <= i_cfg_data;
                slr_pkg::CFG_REAL_COLS: r_real_cols <= i_cfg_data;
                slr_pkg::CFG_VIRT_ROWS: r_virt_rows <= i_cfg_data[6:0];
                slr_pkg::CFG_VIRT_COLS: r_virt_cols <= i_cfg_data[6:0];
                slr_pkg::CFG_GLYPH:     r_glyph <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    slr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_line      (i_line),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    slr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_real_rows (r_real_rows),
        .i_real_cols (r_real_cols),
        .i_virt_rows (r_virt_rows),
        .i_virt_cols (r_virt_cols),
        .i_glyph     (r_glyph),
        .o_empty     (o_empty),
        .o_point     (o_point),
        .i_pop       (i_pop)
    );

    // A command is only taken while the queue holds one.
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid) else $error("command taken from empty queue");

    // A waiting point holds until popped.
    a_point_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_point)))
        else $error("waiting point changed");

endmodule
